@@ rtl/core/hex_frame_receiver_crc16_assert.svh @@
// Assertion macros for the hex frame receiver
`ifndef HEX_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define HEX_FRAME_RECEIVER_CRC16_ASSERT_SVH

// same-cycle implication
`define HFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/hfr_pkg.sv @@
package hfr_pkg;

    localparam int NUM_WORDS   = 5;
    localparam int WORD_W      = 32;
    localparam int CHECK_W     = 16;
    localparam int HEX_START   = 2;
    localparam int HEX_END     = HEX_START + 8 * NUM_WORDS;
    localparam int MIN_LEN     = HEX_END + 2;
    localparam int COUNT_CAP   = MIN_LEN - 1;
    localparam int CNT_W       = $clog2(MIN_LEN);
    localparam int GRP_W       = CNT_W - 3;
    localparam int OUT_RAW_W   = NUM_WORDS * WORD_W + 2 * CHECK_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  CH_NL    = 8'd10;
    localparam logic [7:0]  CH_O     = 8'h6F;
    localparam logic [7:0]  CH_COLON = 8'h3A;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_REJECT  = 2'd1,
        ST_CRC_BAD = 2'd2
    } t_frame_status;

    typedef struct packed {
        t_frame_status                     status;
        logic [CHECK_W-1:0]                computed_check;
        logic [CHECK_W-1:0]                received_check;
        logic [NUM_WORDS-1:0][WORD_W-1:0]  words;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex_digit;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic t_hex_digit hex_decode(input logic [7:0] c);
        t_hex_digit d;
        d.ok  = 1'b1;
        d.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.nib = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.nib = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.nib = 4'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ rtl/core/hex_frame_receiver_crc16.sv @@
// A newline byte's result is registered into the output register, or into the skid entry while the output holds one.
// Throughput: one byte per cycle while s_axis_tready is high; CRC, header and hex updates sit in one stage.
// Output register plus one skid entry; s_axis_tready drops only while both hold results.
// Reset: synchronous, active low; clears line state, sets CRC to 0xFFFF and clears both result valid flags.
module hex_frame_receiver_crc16
    import hfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // word_pose_x, word_pose_y, word_angle,
                                                   // word_speed_lin, word_speed_ang,
                                                   // received_check, computed_check
    output logic [1:0]             m_axis_tuser    // frame_status
);

    logic [15:0]                     r_crc,      n_crc;
    logic [7:0]                      r_byte_d0,  n_byte_d0;
    logic [7:0]                      r_byte_d1,  n_byte_d1;
    logic [CNT_W-1:0]                r_count,    n_count;
    logic                            r_hdr_ok,   n_hdr_ok;
    logic [NUM_WORDS-1:0][WORD_W-1:0] r_words,   n_words;
    logic [NUM_WORDS-1:0]            r_stopped,  n_stopped;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic             in_acc;
    logic             is_nl;
    logic             new_res;
    logic             out_take;
    logic             in_hex;
    logic [CNT_W-1:0] cnt_off;
    logic [GRP_W-1:0] grp;
    t_hex_digit       dig;
    t_result          res;

    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_nl         = (s_axis_tdata == CH_NL);
    assign new_res       = in_acc && is_nl;
    assign out_take      = r_out_valid && m_axis_tready;

    assign cnt_off = r_count - CNT_W'(HEX_START);
    assign grp     = cnt_off[CNT_W-1:3];
    assign in_hex  = (r_count >= CNT_W'(HEX_START)) && (r_count < CNT_W'(HEX_END));
    assign dig     = hex_decode(s_axis_tdata);

    always_comb begin
        res                = '0;
        res.received_check = {r_byte_d0, r_byte_d1};
        res.computed_check = r_crc;
        if ((32'(r_count) + 32'd1 < 32'(MIN_LEN)) || !r_hdr_ok) begin
            res.status         = ST_REJECT;
            res.received_check = '0;
            res.computed_check = '0;
        end else if (res.received_check != r_crc) begin
            res.status = ST_CRC_BAD;
        end else begin
            res.status = ST_VALID;
            res.words  = r_words;
        end
    end

    always_comb begin
        n_crc     = r_crc;
        n_byte_d0 = r_byte_d0;
        n_byte_d1 = r_byte_d1;
        n_count   = r_count;
        n_hdr_ok  = r_hdr_ok;
        n_words   = r_words;
        n_stopped = r_stopped;
        if (in_acc) begin
            if (is_nl) begin
                n_crc     = CRC_INIT;
                n_byte_d0 = '0;
                n_byte_d1 = '0;
                n_count   = '0;
                n_hdr_ok  = 1'b0;
                n_words   = '0;
                n_stopped = '0;
            end else begin
                if (r_count >= CNT_W'(2)) begin
                    n_crc = crc_byte(r_crc, r_byte_d1);
                end
                if (r_count == CNT_W'(1)) begin
                    n_hdr_ok = (r_byte_d0 == CH_O) && (s_axis_tdata == CH_COLON);
                end
                for (int j = 0; j < NUM_WORDS; j++) begin
                    if (in_hex && grp == GRP_W'(j) && !r_stopped[j]) begin
                        if (dig.ok) begin
                            n_words[j] = {r_words[j][WORD_W-5:0], dig.nib};
                        end else begin
                            n_stopped[j] = 1'b1;
                        end
                    end
                end
                n_byte_d1 = r_byte_d0;
                n_byte_d0 = s_axis_tdata;
                if (r_count < CNT_W'(COUNT_CAP)) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (new_res) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_byte_d0    <= '0;
            r_byte_d1    <= '0;
            r_count      <= '0;
            r_hdr_ok     <= 1'b0;
            r_words      <= '0;
            r_stopped    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_crc        <= n_crc;
            r_byte_d0    <= n_byte_d0;
            r_byte_d1    <= n_byte_d1;
            r_count      <= n_count;
            r_hdr_ok     <= n_hdr_ok;
            r_words      <= n_words;
            r_stopped    <= n_stopped;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.computed_check, r_out.received_check,
                                         r_out.words});

`include "hex_frame_receiver_crc16_assert.svh"

    `HFR_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid filled with empty output")
    `HFR_ASSERT_NEXT(a_nl_gives_result, new_res, m_axis_tvalid, "newline produced no result")
    `HFR_ASSERT_NOW(a_valid_crc_match, m_axis_tvalid && m_axis_tuser == ST_VALID,
        r_out.received_check == r_out.computed_check, "valid frame with crc mismatch")
    `HFR_ASSERT_NOW(a_count_capped, 1'b1, r_count <= CNT_W'(COUNT_CAP), "line count overran")

endmodule

@@ tb/tb.sv @@
module tb;
    import hfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        CK_GOOD,
        CK_BAD,
        CK_NONE
    } t_ck_mode;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CHOKE
    } t_rx_mode;

    typedef logic [7:0] t_octets[$];

    typedef struct packed {
        logic [7:0]    b;
        logic          typed;
        t_frame_status st;
    } t_rx_word;

    typedef struct packed {
        t_frame_status                    status;
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
        logic [CHECK_W-1:0]               rx_chk;
        logic [CHECK_W-1:0]               calc_chk;
    } t_frame_rec;

    typedef struct {
        string         body;
        t_ck_mode      ck;
        bit            typed;
        t_frame_status st;
    } t_line_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'd0;    // rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;           // word_pose_x, word_pose_y, word_angle,
                                                    // word_speed_lin, word_speed_ang,
                                                    // received_check, computed_check
    logic [1:0]             m_axis_tuser;           // frame_status

    hex_frame_receiver_crc16 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_line_row line_rows [14] = '{
        '{"", CK_NONE, 1'b1, ST_REJECT},
        '{"o:0000000000000000000000000000000000000000", CK_GOOD, 1'b0, ST_VALID},
        '{"o:FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF", CK_GOOD, 1'b0, ST_VALID},
        '{"o:ffffffffabcdef01ABCDEF2345678989abcDEF01", CK_GOOD, 1'b0, ST_VALID},
        '{"o:0123456789abcdef0123456789ABCDEF01234567", CK_BAD, 1'b1, ST_CRC_BAD},
        '{"x:0123456789abcdef0123456789ABCDEF01234567", CK_GOOD, 1'b1, ST_REJECT},
        '{"o;0123456789abcdef0123456789ABCDEF01234567", CK_GOOD, 1'b1, ST_REJECT},
        '{"O:0123456789abcdef0123456789ABCDEF01234567", CK_GOOD, 1'b1, ST_REJECT},
        '{"o:0123456789abcdef0123456789ABCDEF0123456", CK_GOOD, 1'b0, ST_VALID},
        '{"o:0123456789abcdef0123456789ABCDEF012345", CK_GOOD, 1'b1, ST_REJECT},
        '{"o:12G45678 1234567+12345670x123456-FFFFFFF", CK_GOOD, 1'b0, ST_VALID},
        '{"o:1234:6789abcdef0123456789abcdef012345678", CK_GOOD, 1'b0, ST_VALID},
        '{"o:89ABCDEF0123456789abcdef01234567FEDCBA98 trailing text past the cap",
          CK_GOOD, 1'b0, ST_VALID},
        '{"o:", CK_NONE, 1'b1, ST_REJECT}
    };

    t_rx_word   stim_q[$];
    t_frame_rec frames_due[$];
    int         feed_idx = 0;
    int         taken_idx = 0;
    bit         in_taken = 1'b0;
    int         burst_left = 1;
    int         gap_left = 0;
    int         err_cnt = 0;
    t_rx_mode   rx_mode = RX_OPEN;
    int         rx_hold = 0;

    logic [15:0]                      line_crc;
    logic [7:0]                       last0;
    logic [7:0]                       last1;
    int                               line_len;
    bit                               hdr_seen;
    logic [NUM_WORDS-1:0][WORD_W-1:0] grp_val;
    logic [NUM_WORDS-1:0]             grp_done;

    function automatic logic [15:0] crc16_push(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        bit          fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = r << 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic int nib_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] spoil(input logic [7:0] b);
        logic [7:0] r;
        r = b ^ 8'h80;
        if (r == CH_NL) begin
            r = 8'h0B;
        end
        return r;
    endfunction

    task automatic clear_line();
        line_crc = CRC_INIT;
        last0    = 8'd0;
        last1    = 8'd0;
        line_len = 0;
        hdr_seen = 1'b0;
        grp_val  = '0;
        grp_done = '0;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (err_cnt < 40) begin
            $display("%0t: %s got %h want %h", $realtime, what, got, want);
        end
        err_cnt++;
    endtask

    task automatic add_line(input t_octets body, input t_ck_mode ck, input bit typed,
                            input t_frame_status st);
        logic [15:0] c;
        logic [7:0]  lo;
        logic [7:0]  hi;
        c = CRC_INIT;
        foreach (body[i]) begin
            c = crc16_push(c, body[i]);
            stim_q.insert(stim_q.size(), t_rx_word'{body[i], 1'b0, ST_VALID});
        end
        if (ck != CK_NONE) begin
            lo = c[7:0];
            hi = c[15:8];
            if (ck == CK_BAD) begin
                lo = spoil(lo);
                hi = spoil(hi);
            end
            stim_q.insert(stim_q.size(), t_rx_word'{lo, 1'b0, ST_VALID});
            stim_q.insert(stim_q.size(), t_rx_word'{hi, 1'b0, ST_VALID});
        end
        stim_q.insert(stim_q.size(), t_rx_word'{CH_NL, typed, st});
    endtask

    task automatic absorb_byte(input t_rx_word w);
        t_frame_rec r;
        int         g;
        int         v;
        if (w.b == CH_NL) begin
            r = '0;
            if (line_len + 1 < MIN_LEN || !hdr_seen) begin
                r.status = ST_REJECT;
            end else begin
                r.rx_chk   = {last0, last1};
                r.calc_chk = line_crc;
                if (r.rx_chk != r.calc_chk) begin
                    r.status = ST_CRC_BAD;
                end else begin
                    r.status = ST_VALID;
                    r.words  = grp_val;
                end
            end
            if (w.typed) begin
                if (w.st == ST_REJECT) begin
                    r = '0;
                end
                if (w.st != ST_VALID) begin
                    r.words = '0;
                end
                r.status = w.st;
            end
            frames_due.insert(frames_due.size(), r);
            clear_line();
        end else begin
            if (line_len >= 2) begin
                line_crc = crc16_push(line_crc, last1);
            end
            if (line_len == 1) begin
                hdr_seen = (last0 == CH_O) && (w.b == CH_COLON);
            end
            if (line_len >= HEX_START && line_len < HEX_END) begin
                g = (line_len - HEX_START) / 8;
                if (!grp_done[g]) begin
                    v = nib_of(w.b);
                    if (v < 0) begin
                        grp_done[g] = 1'b1;
                    end else begin
                        grp_val[g] = {grp_val[g][WORD_W-5:0], 4'(v)};
                    end
                end
            end
            last1 = last0;
            last0 = w.b;
            if (line_len < COUNT_CAP) begin
                line_len++;
            end
        end
    endtask

    task automatic check_frame();
        t_frame_rec want;
        if (frames_due.size() == 0) begin
            flag_mismatch("unexpected frame, status", 32'(m_axis_tuser), 32'd0);
        end else begin
            want = frames_due.pop_front();
            if (m_axis_tuser != want.status) begin
                flag_mismatch("frame_status", 32'(m_axis_tuser), 32'(want.status));
            end
            for (int i = 0; i < NUM_WORDS; i++) begin
                if (m_axis_tdata[WORD_W*i +: WORD_W] != want.words[i]) begin
                    flag_mismatch($sformatf("word %0d", i),
                                  m_axis_tdata[WORD_W*i +: WORD_W], want.words[i]);
                end
            end
            if (m_axis_tdata[NUM_WORDS*WORD_W +: CHECK_W] != want.rx_chk) begin
                flag_mismatch("received_check",
                              32'(m_axis_tdata[NUM_WORDS*WORD_W +: CHECK_W]),
                              32'(want.rx_chk));
            end
            if (m_axis_tdata[NUM_WORDS*WORD_W+CHECK_W +: CHECK_W] != want.calc_chk) begin
                flag_mismatch("computed_check",
                              32'(m_axis_tdata[NUM_WORDS*WORD_W+CHECK_W +: CHECK_W]),
                              32'(want.calc_chk));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_byte(stim_q[taken_idx]);
                taken_idx++;
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_frame();
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (feed_idx < stim_q.size()) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stim_q[feed_idx].b;
                feed_idx++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                    gap_left   = $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold <= 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_hold = (rx_mode == RX_CHOKE) ? $urandom_range(150, 400) : $urandom_range(20, 200);
        end
        rx_hold--;
        case (rx_mode)
            RX_OPEN: begin
                m_axis_tready <= 1'b1;
            end
            RX_COIN: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= (rx_hold % 100 == 0);
            end
        endcase
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_octets       body;
        string         hex_chars;
        int            pick;
        int            n;
        logic [7:0]    c;
        t_ck_mode      ck;
        hex_chars = "0123456789abcdefABCDEF";
        clear_line();

        foreach (line_rows[r]) begin
            body.delete();
            for (int i = 0; i < line_rows[r].body.len(); i++) begin
                body.insert(body.size(), line_rows[r].body[i]);
            end
            add_line(body, line_rows[r].ck, line_rows[r].typed, line_rows[r].st);
        end

        while (stim_q.size() < 1000) begin
            body.delete();
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                if (pick < 70) begin
                    body.insert(body.size(), CH_O);
                    body.insert(body.size(), CH_COLON);
                end else begin
                    body.insert(body.size(),
                                ($urandom_range(0, 1) == 0) ? CH_O
                                                            : 8'($urandom_range(0, 255)));
                    body.insert(body.size(), 8'($urandom_range(0, 255)));
                end
                for (int i = 0; i < 8 * NUM_WORDS; i++) begin
                    if ($urandom_range(0, 49) == 0) begin
                        c = 8'($urandom_range(0, 255));
                        body.insert(body.size(), (c == CH_NL) ? 8'h20 : c);
                    end else begin
                        body.insert(body.size(),
                                    hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
                    end
                end
                if ($urandom_range(0, 14) == 0) begin
                    n = $urandom_range(1, 3);
                    repeat (n) void'(body.pop_back());
                end
                if ($urandom_range(0, 7) == 0) begin
                    n = $urandom_range(1, 20);
                    repeat (n) body.insert(body.size(), 8'($urandom_range(8'h20, 8'h7E)));
                end
                ck = ($urandom_range(0, 9) == 0) ? CK_BAD : CK_GOOD;
            end else begin
                n = $urandom_range(0, 60);
                repeat (n) body.insert(body.size(), 8'($urandom_range(0, 255)));
                ck = t_ck_mode'($urandom_range(0, 2));
            end
            add_line(body, ck, 1'b0, ST_VALID);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_idx < stim_q.size()) @(posedge i_clk);
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/hfr_pkg.sv
rtl/core/hex_frame_receiver_crc16.sv
tb/tb.sv
